[design/gap_pkg.sv]
// shared types and constants for the grid path search block
// no dependencies
package gap_pkg;

  localparam int CELL_COUNT = 1024;
  localparam int IDX_W      = $clog2(CELL_COUNT);
  localparam int CNT_W      = IDX_W + 1;
  localparam int DIM_W      = 11;
  localparam int G_W        = 11;
  localparam int F_W        = 12;

  localparam logic [G_W-1:0] G_MAX = '1;
  localparam logic [F_W-1:0] F_MAX = '1;

  // operation codes
  localparam logic [1:0] OP_WALL   = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // per-cell flag bit positions
  localparam int FL_OPEN   = 0;
  localparam int FL_CLOSED = 1;
  localparam int FL_PATH   = 2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [IDX_W-1:0] cell_index;
    logic             wall_flag;
    logic [IDX_W-1:0] start_cell;
    logic [IDX_W-1:0] goal_cell;
  } in_item_t;

  typedef struct packed {
    logic             path_found;
    logic [G_W-1:0]   path_cost;
    logic             on_path;
    logic             is_closed;
    logic             is_blocked;
    logic [IDX_W-1:0] parent_cell;
  } out_item_t;

  // one word of per-search cell state
  typedef struct packed {
    logic [G_W-1:0]   g;
    logic [F_W-1:0]   f;
    logic [IDX_W-1:0] parent;
    logic [2:0]       flags;
  } cell_ent_t;

endpackage

[design/grid_astar_path_search.sv]
// top level of the grid path search block: sequencer, cell stores, ports
// depends on gap_pkg
//
// One item at a time; busy is high from acceptance until the result strobe.
// A wall write passes through S_ZOUT and a cell read through S_RDOUT before the result strobe.
// A search first sweeps the per-cell store clear, then for every
// expansion scans the cells in use through the single store read port
// and visits the four neighbors in S_NBRD and S_NBEV, skipping S_NBEV
// when a neighbor is off the grid; marking the path walks S_PTRD, S_PTCHK,
// S_PTRD2 and S_PTWR for each path cell. The scan over the store read port
// sets the search time. After reset a clearing pass runs with busy high;
// configuration writes are taken at any time.
// The result beat is shown for one cycle on out_valid and cannot be stalled.
module grid_astar_path_search
  import gap_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_OPEN  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_SEND  = 4'd4;
  localparam logic [3:0] S_NBRD  = 4'd5;
  localparam logic [3:0] S_NBEV  = 4'd6;
  localparam logic [3:0] S_PTRD  = 4'd7;
  localparam logic [3:0] S_PTCHK = 4'd8;
  localparam logic [3:0] S_PTRD2 = 4'd9;
  localparam logic [3:0] S_PTWR  = 4'd10;
  localparam logic [3:0] S_RDOUT = 4'd11;
  localparam logic [3:0] S_ZOUT  = 4'd12;

  localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(CELL_COUNT - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CELL_COUNT);

  // cell stores
  cell_ent_t        ent_mem [CELL_COUNT];
  logic             wall_mem [CELL_COUNT];
  cell_ent_t        ent_rd_r;
  logic             wall_rd_r;
  logic             s_we, w_we, w_wd;
  logic [IDX_W-1:0] s_wa, w_wa, rd_a;
  cell_ent_t        s_wd;

  always_ff @(posedge clk) begin
    if (s_we) ent_mem[s_wa] <= s_wd;
    if (w_we) wall_mem[w_wa] <= w_wd;
    ent_rd_r  <= ent_mem[rd_a];
    wall_rd_r <= wall_mem[rd_a];
  end

  // control and working registers
  logic [3:0]       state_r, state_nxt;
  logic             clr_wall_r, clr_wall_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [DIM_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic             pv_r, pv_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic [DIM_W-1:0] prow_r, prow_nxt, pcol_r, pcol_nxt;
  logic             any_r, any_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [DIM_W-1:0] best_row_r, best_row_nxt, best_col_r, best_col_nxt;
  cell_ent_t        best_ent_r, best_ent_nxt;
  logic [DIM_W-1:0] rows_cfg_r, rows_cfg_nxt, cols_cfg_r, cols_cfg_nxt;
  logic [DIM_W-1:0] cols_r, cols_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] start_r, start_nxt, goal_r, goal_nxt;
  logic [DIM_W-1:0] goal_row_r, goal_row_nxt, goal_col_r, goal_col_nxt;
  logic [1:0]       j_r, j_nxt;
  logic [IDX_W-1:0] nb_r, nb_nxt;
  logic [F_W-1:0]   manh_r, manh_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0] steps_r, steps_nxt;
  logic [G_W-1:0]   res_cost_r, res_cost_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  // combinational helpers
  logic             go_scan, fin;
  logic             fin_found;
  logic [G_W-1:0]   fin_cost;
  logic [DIM_W-1:0] rows_eff, cols_eff;
  logic [2*DIM_W-1:0] cells_prod;
  logic             nb_ok;
  logic [CNT_W:0]   nb_sum;
  logic [DIM_W-1:0] nr, nc, dr, dc;
  logic [G_W:0]     g_inc;
  logic [G_W-1:0]   g_new;
  logic [F_W:0]     f_sum;
  logic [IDX_W-1:0] pt_parent;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // grid size seen by a new search
  assign rows_eff   = (rows_cfg_r == '0) ? DIM_W'(1) : rows_cfg_r;
  assign cols_eff   = (cols_cfg_r == '0) ? DIM_W'(1) : cols_cfg_r;
  assign cells_prod = rows_eff * cols_eff;

  // neighbor of the expanded cell, picked by j
  always_comb begin
    nb_sum = '0;
    nb_ok  = 1'b0;
    nr     = best_row_r;
    nc     = best_col_r;
    case (j_r)
      2'd0: begin
        nb_sum = {2'b0, best_idx_r} - (CNT_W+1)'(1);
        nb_ok  = (best_col_r != '0);
        nc     = best_col_r - DIM_W'(1);
      end
      2'd1: begin
        nb_sum = {2'b0, best_idx_r} - {1'b0, cols_r};
        nb_ok  = (best_row_r != '0);
        nr     = best_row_r - DIM_W'(1);
      end
      2'd2: begin
        nb_sum = {2'b0, best_idx_r} + (CNT_W+1)'(1);
        nb_ok  = ((best_col_r + DIM_W'(1)) != cols_r) && (nb_sum < {1'b0, count_r});
        nc     = best_col_r + DIM_W'(1);
      end
      default: begin
        nb_sum = {2'b0, best_idx_r} + {1'b0, cols_r};
        nb_ok  = (nb_sum < {1'b0, count_r});
        nr     = best_row_r + DIM_W'(1);
      end
    endcase
    dr = (nr > goal_row_r) ? nr - goal_row_r : goal_row_r - nr;
    dc = (nc > goal_col_r) ? nc - goal_col_r : goal_col_r - nc;
  end

  // score update for a neighbor
  assign g_inc     = {1'b0, best_ent_r.g} + (G_W+1)'(1);
  assign g_new     = (g_inc > {1'b0, G_MAX}) ? G_MAX : g_inc[G_W-1:0];
  assign f_sum     = {2'b0, g_new} + {1'b0, manh_r};
  assign pt_parent = ent_rd_r.parent;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_wall_nxt = clr_wall_r;
    idx_nxt      = idx_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    pv_nxt       = 1'b0;
    pidx_nxt     = pidx_r;
    prow_nxt     = prow_r;
    pcol_nxt     = pcol_r;
    any_nxt      = any_r;
    best_idx_nxt = best_idx_r;
    best_row_nxt = best_row_r;
    best_col_nxt = best_col_r;
    best_ent_nxt = best_ent_r;
    rows_cfg_nxt = rows_cfg_r;
    cols_cfg_nxt = cols_cfg_r;
    cols_nxt     = cols_r;
    count_nxt    = count_r;
    start_nxt    = start_r;
    goal_nxt     = goal_r;
    goal_row_nxt = goal_row_r;
    goal_col_nxt = goal_col_r;
    j_nxt        = j_r;
    nb_nxt       = nb_r;
    manh_nxt     = manh_r;
    cur_nxt      = cur_r;
    steps_nxt    = steps_r;
    res_cost_nxt = res_cost_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    s_we = 1'b0;
    s_wa = '0;
    s_wd = '0;
    w_we = 1'b0;
    w_wa = in_data.cell_index;
    w_wd = in_data.wall_flag;
    rd_a = '0;
    go_scan   = 1'b0;
    fin       = 1'b0;
    fin_found = 1'b0;
    fin_cost  = '0;

    // configuration beat
    if (cfg_valid) begin
      if (cfg_index == CFG_ROWS) rows_cfg_nxt = cfg_data;
      else                       cols_cfg_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        rd_a = in_data.cell_index;
        if (start) begin
          case (in_data.operation)
            OP_WALL: begin
              w_we      = 1'b1;
              state_nxt = S_ZOUT;
            end
            OP_SEARCH: begin
              start_nxt = in_data.start_cell;
              goal_nxt  = in_data.goal_cell;
              cols_nxt  = cols_eff;
              count_nxt = (cells_prod > (2*DIM_W)'(CELL_COUNT)) ? FULL_CNT
                                                               : cells_prod[CNT_W-1:0];
              idx_nxt   = '0;
              row_nxt   = '0;
              col_nxt   = '0;
              state_nxt = S_CLR;
            end
            OP_READ: state_nxt = S_RDOUT;
            default: state_nxt = S_ZOUT;
          endcase
        end
      end

      // clearing sweep, also finds the goal's row and column
      S_CLR: begin
        s_we = 1'b1;
        s_wa = idx_r[IDX_W-1:0];
        s_wd = '0;
        w_wa = idx_r[IDX_W-1:0];
        w_wd = 1'b0;
        w_we = clr_wall_r;
        if (idx_r[IDX_W-1:0] == goal_r) begin
          goal_row_nxt = row_r;
          goal_col_nxt = col_r;
        end
        idx_nxt = idx_r + CNT_W'(1);
        if (col_r + DIM_W'(1) == cols_r) begin
          col_nxt = '0;
          row_nxt = row_r + DIM_W'(1);
        end else begin
          col_nxt = col_r + DIM_W'(1);
        end
        if (idx_r == LAST_CELL) begin
          if (clr_wall_r) begin
            clr_wall_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end else if ({1'b0, start_r} >= count_r || {1'b0, goal_r} >= count_r) begin
            fin = 1'b1;
          end else begin
            state_nxt = S_OPEN;
          end
        end
      end

      S_OPEN: begin
        s_we    = 1'b1;
        s_wa    = start_r;
        s_wd    = '0;
        s_wd.flags[FL_OPEN] = 1'b1;
        go_scan = 1'b1;
      end

      // lowest f over the open cells, one read per cycle
      S_SCAN: begin
        rd_a = idx_r[IDX_W-1:0];
        if (idx_r < count_r) begin
          pv_nxt   = 1'b1;
          pidx_nxt = idx_r[IDX_W-1:0];
          prow_nxt = row_r;
          pcol_nxt = col_r;
          idx_nxt  = idx_r + CNT_W'(1);
          if (col_r + DIM_W'(1) == cols_r) begin
            col_nxt = '0;
            row_nxt = row_r + DIM_W'(1);
          end else begin
            col_nxt = col_r + DIM_W'(1);
          end
        end else if (!pv_r) begin
          state_nxt = S_SEND;
        end
        if (pv_r && ent_rd_r.flags[FL_OPEN] && (!any_r || ent_rd_r.f < best_ent_r.f)) begin
          any_nxt      = 1'b1;
          best_idx_nxt = pidx_r;
          best_row_nxt = prow_r;
          best_col_nxt = pcol_r;
          best_ent_nxt = ent_rd_r;
        end
      end

      S_SEND: begin
        if (!any_r) begin
          fin = 1'b1;
        end else if (best_idx_r == goal_r) begin
          res_cost_nxt = best_ent_r.g;
          if (goal_r == start_r) begin
            fin       = 1'b1;
            fin_found = 1'b1;
            fin_cost  = best_ent_r.g;
          end else begin
            cur_nxt   = goal_r;
            steps_nxt = '0;
            state_nxt = S_PTRD;
          end
        end else begin
          s_we = 1'b1;
          s_wa = best_idx_r;
          s_wd = best_ent_r;
          s_wd.flags[FL_OPEN]   = 1'b0;
          s_wd.flags[FL_CLOSED] = 1'b1;
          j_nxt     = '0;
          state_nxt = S_NBRD;
        end
      end

      S_NBRD: begin
        rd_a = nb_sum[IDX_W-1:0];
        if (nb_ok) begin
          nb_nxt    = nb_sum[IDX_W-1:0];
          manh_nxt  = {1'b0, dr} + {1'b0, dc};
          state_nxt = S_NBEV;
        end else if (j_r == 2'd3) begin
          go_scan = 1'b1;
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end

      S_NBEV: begin
        s_wa = nb_r;
        if (!ent_rd_r.flags[FL_CLOSED]) begin
          if (wall_rd_r) begin
            s_we = 1'b1;
            s_wd = ent_rd_r;
            s_wd.flags[FL_CLOSED] = 1'b1;
          end else if (!ent_rd_r.flags[FL_OPEN] || g_new < ent_rd_r.g) begin
            s_we = 1'b1;
            s_wd = ent_rd_r;
            s_wd.g      = g_new;
            s_wd.f      = (f_sum > {1'b0, F_MAX}) ? F_MAX : f_sum[F_W-1:0];
            s_wd.parent = best_idx_r;
            s_wd.flags[FL_OPEN] = 1'b1;
          end
        end
        if (j_r == 2'd3) begin
          go_scan = 1'b1;
        end else begin
          j_nxt     = j_r + 2'd1;
          state_nxt = S_NBRD;
        end
      end

      // walk the parent chain back from the goal
      S_PTRD: begin
        rd_a      = cur_r;
        state_nxt = S_PTCHK;
      end

      S_PTCHK: begin
        steps_nxt = steps_r + CNT_W'(1);
        cur_nxt   = pt_parent;
        if ({1'b0, pt_parent} >= count_r || pt_parent == start_r) begin
          fin       = 1'b1;
          fin_found = 1'b1;
          fin_cost  = res_cost_r;
        end else begin
          state_nxt = S_PTRD2;
        end
      end

      S_PTRD2: begin
        rd_a      = cur_r;
        state_nxt = S_PTWR;
      end

      S_PTWR: begin
        s_we = 1'b1;
        s_wa = cur_r;
        s_wd = ent_rd_r;
        s_wd.flags[FL_PATH] = 1'b1;
        if (steps_r < count_r) begin
          state_nxt = S_PTRD;
        end else begin
          fin       = 1'b1;
          fin_found = 1'b1;
          fin_cost  = res_cost_r;
        end
      end

      S_RDOUT: begin
        out_valid_nxt          = 1'b1;
        out_data_nxt           = '0;
        out_data_nxt.path_cost = ent_rd_r.g;
        out_data_nxt.on_path   = ent_rd_r.flags[FL_PATH];
        out_data_nxt.is_closed = ent_rd_r.flags[FL_CLOSED];
        out_data_nxt.is_blocked  = wall_rd_r;
        out_data_nxt.parent_cell = ent_rd_r.parent;
        state_nxt              = S_IDLE;
      end

      S_ZOUT: begin
        fin = 1'b1;
      end

      default: state_nxt = S_IDLE;
    endcase

    // start a new scan pass
    if (go_scan) begin
      idx_nxt   = '0;
      row_nxt   = '0;
      col_nxt   = '0;
      any_nxt   = 1'b0;
      state_nxt = S_SCAN;
    end

    // search or zero result beat
    if (fin) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt            = '0;
      out_data_nxt.path_found = fin_found;
      out_data_nxt.path_cost  = fin_cost;
      state_nxt               = S_IDLE;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_wall_r  <= 1'b1;
      idx_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      pv_r        <= 1'b0;
      any_r       <= 1'b0;
      rows_cfg_r  <= DIM_W'(32);
      cols_cfg_r  <= DIM_W'(32);
      cols_r      <= DIM_W'(32);
      count_r     <= FULL_CNT;
      j_r         <= '0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_wall_r  <= clr_wall_nxt;
      idx_r       <= idx_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      pv_r        <= pv_nxt;
      any_r       <= any_nxt;
      rows_cfg_r  <= rows_cfg_nxt;
      cols_cfg_r  <= cols_cfg_nxt;
      cols_r      <= cols_nxt;
      count_r     <= count_nxt;
      j_r         <= j_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working data
  always_ff @(posedge clk) begin
    pidx_r     <= pidx_nxt;
    prow_r     <= prow_nxt;
    pcol_r     <= pcol_nxt;
    best_idx_r <= best_idx_nxt;
    best_row_r <= best_row_nxt;
    best_col_r <= best_col_nxt;
    best_ent_r <= best_ent_nxt;
    start_r    <= start_nxt;
    goal_r     <= goal_nxt;
    goal_row_r <= goal_row_nxt;
    goal_col_r <= goal_col_nxt;
    nb_r       <= nb_nxt;
    manh_r     <= manh_nxt;
    cur_r      <= cur_nxt;
    res_cost_r <= res_cost_nxt;
    out_data_r <= out_data_nxt;
  end

  // checks
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result beat longer than one cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted item left block idle");

  a_idle_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result beat while still working");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> idx_r <= count_r) else $error("scan ran past grid");

  a_path_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PTWR |-> steps_r <= count_r) else $error("path walk ran too long");

endmodule
